@@ hdl/ude_pkg.sv @@
// ----------------------------------------------------------------------------
// ude_pkg: shared definitions for the decimal digit emitter
// Width selectors, conversion sizes, state type and the BCD dabble step.
// ----------------------------------------------------------------------------
`default_nettype none

package ude_pkg;

  // Bit width of a "long" number, clamped to 32..64.
  localparam int WIDE_BITS_RAW = 64;
  localparam int WIDE_BITS     = (WIDE_BITS_RAW < 32) ? 32 :
                                 (WIDE_BITS_RAW > 64) ? 64 : WIDE_BITS_RAW;

  localparam int VALUE_W       = 64;
  localparam int BITS_PER_STEP = 4;
  localparam int NUM_DIGITS    = 20;

  localparam int SHORT_BITS  = 16;
  localparam int PLAIN_BITS  = 32;
  localparam int SHORT_STEPS = (SHORT_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int PLAIN_STEPS = (PLAIN_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int LONG_STEPS  = (WIDE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;

  localparam int STEP_W = (LONG_STEPS > 1) ? $clog2(LONG_STEPS) : 1;
  localparam int PTR_W  = $clog2(NUM_DIGITS);

  // Most significant digit position that each width can reach.
  localparam int SHORT_TOP = 4;
  localparam int PLAIN_TOP = 9;
  localparam int LONG_TOP  = NUM_DIGITS - 1;

  localparam logic [VALUE_W-1:0] SHORT_MASK = {VALUE_W{1'b1}} >> (VALUE_W - SHORT_BITS);
  localparam logic [VALUE_W-1:0] PLAIN_MASK = {VALUE_W{1'b1}} >> (VALUE_W - PLAIN_BITS);
  localparam logic [VALUE_W-1:0] LONG_MASK  = {VALUE_W{1'b1}} >> (VALUE_W - WIDE_BITS);

  // Left alignment so that the first step consumes the top nibble of the width.
  localparam int SHORT_ALIGN = VALUE_W - SHORT_STEPS * BITS_PER_STEP;
  localparam int PLAIN_ALIGN = VALUE_W - PLAIN_STEPS * BITS_PER_STEP;
  localparam int LONG_ALIGN  = VALUE_W - LONG_STEPS * BITS_PER_STEP;

  localparam logic [1:0] SEL_PLAIN = 2'd0;
  localparam logic [1:0] SEL_LONG  = 2'd1;
  localparam logic [1:0] SEL_SHORT = 2'd2;

  localparam logic [5:0] ASCII_ZERO = 6'd48;

  typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_e;

  // One double-dabble bit: correct every digit of 5 or more, then shift in.
  function automatic bcd_t dabble_bit(input bcd_t bcd, input logic bit_in);
    bcd_t                      corr;
    logic [NUM_DIGITS*4-1:0]   flat;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      corr[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
    flat = corr;
    flat = {flat[NUM_DIGITS*4-2:0], bit_in};
    return bcd_t'(flat);
  endfunction

endpackage

`default_nettype wire

@@ hdl/unsigned_decimal_digit_emitter.sv @@
// ----------------------------------------------------------------------------
// unsigned_decimal_digit_emitter: binary to decimal ASCII conversion
// Converts a 16/32/64-bit unsigned number to its decimal digits, most
// significant first, no leading zeros, with last flag and digit count.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------
//   in      | to block  | in_valid_i / in_stall_o | command_i, value_i
//   out     | from block| out_valid_o/ out_stall_i| digit_char_o, last_o, char_count_o
//
// Sequence: a request is accepted in idle, then takes S 4-bit double-dabble
// steps (4 short, 8 plain, 16 long), skips Z leading zero digits (at most
// 4, 9 or 19) and emits D digits; the skip state ends once it finds the
// first digit. The shared dabble unit handles four bits per cycle; the digit
// read-out emits one character per cycle from the output register while the
// output is not stalled.
// Reset clears the sequencer and the output valid; digit storage is not reset.
// A stalled output holds the current character and the sequencer waits in its emit state.
// ----------------------------------------------------------------------------
`default_nettype none

module unsigned_decimal_digit_emitter (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [63:0] value_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [5:0]      digit_char_o,
  output logic            last_o,
  output logic [4:0]      char_count_o
);

  ude_pkg::state_e state_q, state_d;

  logic [ude_pkg::VALUE_W-1:0] bin_q, bin_d;
  ude_pkg::bcd_t               bcd_q, bcd_d;
  logic [ude_pkg::STEP_W-1:0]  step_q, step_d;
  logic [ude_pkg::PTR_W-1:0]   ptr_q, ptr_d;
  logic [4:0]                  cnt_q, cnt_d;

  logic       out_valid_q, out_valid_d;
  logic [5:0] digit_q, digit_d;
  logic       last_q, last_d;
  logic [4:0] count_q, count_d;

  logic          accept;
  logic          slot_free;
  logic [3:0]    cur_digit;
  ude_pkg::bcd_t bcd_step;

  // Request accepted only while the sequencer is idle.
  assign in_stall_o = (state_q != ude_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Output register can take a new character when empty or being drained.
  assign slot_free = !out_valid_q || !out_stall_i;
  assign cur_digit = bcd_q[ptr_q];

  // Shared dabble unit: four dependent bit steps from the top of bin_q.
  always_comb begin
    bcd_step = bcd_q;
    for (int b = 0; b < ude_pkg::BITS_PER_STEP; b++) begin
      bcd_step = ude_pkg::dabble_bit(bcd_step, bin_q[ude_pkg::VALUE_W-1-b]);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ude_pkg::ST_IDLE: begin
        if (accept) state_d = ude_pkg::ST_CONV;
      end
      ude_pkg::ST_CONV: begin
        if (step_q == '0) state_d = ude_pkg::ST_SKIP;
      end
      ude_pkg::ST_SKIP: begin
        if (cur_digit != 4'd0 || ptr_q == '0) state_d = ude_pkg::ST_EMIT;
      end
      ude_pkg::ST_EMIT: begin
        if (slot_free && ptr_q == '0) state_d = ude_pkg::ST_IDLE;
      end
      default: state_d = ude_pkg::ST_IDLE;
    endcase
  end

  // Datapath and output register.
  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    step_d = step_q;
    ptr_d  = ptr_q;
    cnt_d  = cnt_q;

    out_valid_d = out_valid_q && out_stall_i;
    digit_d     = digit_q;
    last_d      = last_q;
    count_d     = count_q;

    case (state_q)
      ude_pkg::ST_IDLE: begin
        if (accept) begin
          bcd_d = '0;
          cnt_d = '0;
          case (command_i)
            ude_pkg::SEL_LONG: begin
              bin_d  = (value_i & ude_pkg::LONG_MASK) << ude_pkg::LONG_ALIGN;
              step_d = ude_pkg::STEP_W'(ude_pkg::LONG_STEPS - 1);
              ptr_d  = ude_pkg::PTR_W'(ude_pkg::LONG_TOP);
            end
            ude_pkg::SEL_SHORT: begin
              bin_d  = (value_i & ude_pkg::SHORT_MASK) << ude_pkg::SHORT_ALIGN;
              step_d = ude_pkg::STEP_W'(ude_pkg::SHORT_STEPS - 1);
              ptr_d  = ude_pkg::PTR_W'(ude_pkg::SHORT_TOP);
            end
            default: begin
              bin_d  = (value_i & ude_pkg::PLAIN_MASK) << ude_pkg::PLAIN_ALIGN;
              step_d = ude_pkg::STEP_W'(ude_pkg::PLAIN_STEPS - 1);
              ptr_d  = ude_pkg::PTR_W'(ude_pkg::PLAIN_TOP);
            end
          endcase
        end
      end
      ude_pkg::ST_CONV: begin
        bcd_d  = bcd_step;
        bin_d  = bin_q << ude_pkg::BITS_PER_STEP;
        step_d = step_q - 1'b1;
      end
      ude_pkg::ST_SKIP: begin
        // Drop leading zeros; the units digit always stays.
        if (cur_digit == 4'd0 && ptr_q != '0) ptr_d = ptr_q - 1'b1;
      end
      ude_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          digit_d     = ude_pkg::ASCII_ZERO + {2'b00, cur_digit};
          last_d      = (ptr_q == '0);
          count_d     = (ptr_q == '0) ? cnt_q + 5'd1 : 5'd0;
          cnt_d       = cnt_q + 5'd1;
          if (ptr_q != '0) ptr_d = ptr_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ude_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q   <= bin_d;
    bcd_q   <= bcd_d;
    step_q  <= step_d;
    ptr_q   <= ptr_d;
    cnt_q   <= cnt_d;
    digit_q <= digit_d;
    last_q  <= last_d;
    count_q <= count_d;
  end

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = digit_q;
  assign last_o       = last_q;
  assign char_count_o = count_q;

  // Count appears exactly on the final digit.
  a_count_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (char_count_o != 5'd0)))
    else $error("char_count and last disagree");

  // Every character is a decimal digit.
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (digit_char_o >= 6'd48 && digit_char_o <= 6'd57))
    else $error("non-decimal character emitted");

  // A request blocks the input until its conversion completes.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("input not stalled after request");

  // Digit pointer stays inside the digit store.
  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ude_pkg::ST_SKIP || state_q == ude_pkg::ST_EMIT)
      |-> (ptr_q < ude_pkg::PTR_W'(ude_pkg::NUM_DIGITS)))
    else $error("digit pointer out of range");

endmodule

`default_nettype wire
